[rtl/pdf_pkg.sv]
// Package for the deadband PID controller: widths, filter constants, register codes, types.
`default_nettype none
package pdf_pkg;

  localparam int unsigned MEAS_W  = 16;
  localparam int unsigned ERR_W   = 17;
  localparam int unsigned DIFF_W  = 18;
  localparam int unsigned ACC_W   = 48;
  localparam int unsigned SUM_W   = 36;
  localparam int unsigned FILT_W  = 45;
  localparam int unsigned MUL_A_W = 25;
  localparam int unsigned MUL_B_W = 37;
  localparam int unsigned PROD_W  = 48;
  localparam int unsigned SAT_W   = FILT_W - 8;
  localparam int unsigned CFG_AW  = 5;
  localparam int unsigned CFG_DW  = 32;

  // 0.3 / 0.7 filter weights in Q8
  localparam int unsigned FILT_NEW   = 77;
  localparam int unsigned FILT_OLD   = 179;
  localparam int unsigned FILT_SHIFT = 8;

  typedef enum logic [2:0] {
    REG_TARGET     = 3'd0,
    REG_DEAD_BAND  = 3'd1,
    REG_INT_LIMIT  = 3'd2,
    REG_MAX_OUTPUT = 3'd3,
    REG_GAIN_P     = 3'd4,
    REG_GAIN_I     = 3'd5,
    REG_GAIN_D     = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [15:0] target_value;
    logic [14:0] dead_band;
    logic [15:0] integral_limit;
    logic [14:0] max_output;
    logic [15:0] gain_p;
    logic [23:0] gain_i;
    logic [15:0] gain_d;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_I,
    ST_ACC,
    ST_CLAMP,
    ST_SUM,
    ST_MUL_N,
    ST_MUL_O,
    ST_FILT,
    ST_SAT,
    ST_OUT
  } state_e;

endpackage
`default_nettype wire

[rtl/pdf_mul.sv]
// Shared signed multiplier with registered product.
`default_nettype none
module pdf_mul (
  input  wire logic                                clk_i,
  input  wire logic                                en_i,
  input  wire logic signed [pdf_pkg::MUL_A_W-1:0]  a_i,
  input  wire logic signed [pdf_pkg::MUL_B_W-1:0]  b_i,
  output logic signed      [pdf_pkg::PROD_W-1:0]   p_o
);

  localparam int unsigned FULL_W = pdf_pkg::MUL_A_W + pdf_pkg::MUL_B_W;

  logic signed [FULL_W-1:0]         full;
  logic signed [pdf_pkg::PROD_W-1:0] p_d, p_q;

  assign full = a_i * b_i;
  // all products of this block fit in PROD_W bits
  assign p_d  = pdf_pkg::PROD_W'(full);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= p_d;
    end
  end

  assign p_o = p_q;

endmodule
`default_nettype wire

[rtl/pdf_cfg.sv]
// APB register file for the controller settings.
`default_nettype none
module pdf_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [pdf_pkg::CFG_AW-1:0]    paddr,
  input  wire logic [pdf_pkg::CFG_DW-1:0]    pwdata,
  output logic      [pdf_pkg::CFG_DW-1:0]    prdata,
  output logic                               pready,
  output pdf_pkg::cfg_t                      cfg_o
);

  pdf_pkg::cfg_t    cfg_d, cfg_q;
  pdf_pkg::reg_idx_e idx;
  logic             wr_en;

  assign idx    = pdf_pkg::reg_idx_e'(paddr[pdf_pkg::CFG_AW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        pdf_pkg::REG_TARGET:     cfg_d.target_value   = pwdata[15:0];
        pdf_pkg::REG_DEAD_BAND:  cfg_d.dead_band      = pwdata[14:0];
        pdf_pkg::REG_INT_LIMIT:  cfg_d.integral_limit = pwdata[15:0];
        pdf_pkg::REG_MAX_OUTPUT: cfg_d.max_output     = pwdata[14:0];
        pdf_pkg::REG_GAIN_P:     cfg_d.gain_p         = pwdata[15:0];
        pdf_pkg::REG_GAIN_I:     cfg_d.gain_i         = pwdata[23:0];
        pdf_pkg::REG_GAIN_D:     cfg_d.gain_d         = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      pdf_pkg::REG_TARGET:     prdata = {16'd0, cfg_q.target_value};
      pdf_pkg::REG_DEAD_BAND:  prdata = {17'd0, cfg_q.dead_band};
      pdf_pkg::REG_INT_LIMIT:  prdata = {16'd0, cfg_q.integral_limit};
      pdf_pkg::REG_MAX_OUTPUT: prdata = {17'd0, cfg_q.max_output};
      pdf_pkg::REG_GAIN_P:     prdata = {16'd0, cfg_q.gain_p};
      pdf_pkg::REG_GAIN_I:     prdata = {8'd0, cfg_q.gain_i};
      pdf_pkg::REG_GAIN_D:     prdata = {16'd0, cfg_q.gain_d};
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

[rtl/pid_deadband_filtered.sv]
// PID controller with deadband, clamped integral and 0.3/0.7 output filter.
// Outside the deadband an accepted measure transaction passes MUL_I, ACC, CLAMP, SUM, MUL_N,
//   MUL_O, FILT, SAT and OUT before drive_valid_o; inside it MUL_I goes straight to OUT
//   (output holds its last value). The sequencer shares one multiplier over five products,
//   and a new sample is taken only when idle.
// Reset: rst_ni clears settings, previous error, integral, previous drive and output valid.
`default_nettype none
module pid_deadband_filtered #(
  parameter int unsigned KI_FRAC_BITS = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // configuration
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [pdf_pkg::CFG_AW-1:0]  paddr,
  input  wire logic [pdf_pkg::CFG_DW-1:0]  pwdata,
  output logic      [pdf_pkg::CFG_DW-1:0]  prdata,
  output logic                             pready,
  // measure channel
  input  wire logic signed [15:0]          measure_i,
  input  wire logic                        measure_valid_i,
  output logic                             measure_stall_o,
  // drive channel
  output logic signed [15:0]               drive_o,
  output logic                             drive_valid_o,
  input  wire logic                        drive_stall_i
);

  localparam int unsigned ERR_W   = pdf_pkg::ERR_W;
  localparam int unsigned DIFF_W  = pdf_pkg::DIFF_W;
  localparam int unsigned ACC_W   = pdf_pkg::ACC_W;
  localparam int unsigned SUM_W   = pdf_pkg::SUM_W;
  localparam int unsigned FILT_W  = pdf_pkg::FILT_W;
  localparam int unsigned SAT_W   = pdf_pkg::SAT_W;
  localparam int unsigned MUL_A_W = pdf_pkg::MUL_A_W;
  localparam int unsigned MUL_B_W = pdf_pkg::MUL_B_W;
  localparam int unsigned PROD_W  = pdf_pkg::PROD_W;

  pdf_pkg::cfg_t cfg;

  pdf_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  pdf_pkg::state_e state_d, state_q;

  logic signed [ERR_W-1:0]  err_d, err_q;          // error of the current sample
  logic signed [DIFF_W-1:0] diff_d, diff_q;        // err - previous err
  logic signed [ERR_W-1:0]  prev_error_d, prev_error_q;
  logic signed [ACC_W-1:0]  acc_d, acc_q;          // integral, Q.KI_FRAC_BITS
  logic signed [SUM_W-1:0]  sum_d, sum_q;          // P + I + D
  logic signed [FILT_W-1:0] filt_d, filt_q;        // 77*sum + 179*prev_drive
  logic signed [15:0]       prev_drive_d, prev_drive_q;
  logic signed [15:0]       drive_d, drive_q;
  logic                     drive_valid_d, drive_valid_q;

  // shared multiplier
  logic                      mul_en;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;

  pdf_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // ---------------------------------------------------------------------------
  // Datapath helpers
  // ---------------------------------------------------------------------------
  logic                     in_fire, out_free;
  logic signed [ERR_W-1:0]  err_new;
  logic [ERR_W-1:0]         err_mag;
  logic                     active;
  logic signed [ACC_W-1:0]  lim, lim_neg;
  logic signed [SAT_W-1:0]  filt_sh, mo_pos, mo_neg;

  assign in_fire  = measure_valid_i && !measure_stall_o;
  assign out_free = !drive_valid_q || !drive_stall_i;

  assign err_new = ERR_W'($signed(cfg.target_value)) - ERR_W'(measure_i);
  // magnitude read as unsigned so the most negative error still works
  assign err_mag = err_q[ERR_W-1] ? ERR_W'(-err_q) : ERR_W'(err_q);
  assign active  = err_mag > ERR_W'(cfg.dead_band);

  assign lim     = $signed(ACC_W'(cfg.integral_limit) << KI_FRAC_BITS);
  assign lim_neg = -lim;

  assign filt_sh = SAT_W'(filt_q >>> pdf_pkg::FILT_SHIFT);
  assign mo_pos  = $signed(SAT_W'(cfg.max_output));
  assign mo_neg  = -mo_pos;

  // ---------------------------------------------------------------------------
  // Sequencer: next state, operand select and register updates
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d       = state_q;
    err_d         = err_q;
    diff_d        = diff_q;
    prev_error_d  = prev_error_q;
    acc_d         = acc_q;
    sum_d         = sum_q;
    filt_d        = filt_q;
    prev_drive_d  = prev_drive_q;
    drive_d       = drive_q;
    drive_valid_d = drive_valid_q && drive_stall_i;
    mul_en        = 1'b0;
    mul_a         = '0;
    mul_b         = '0;

    unique case (state_q)
      pdf_pkg::ST_IDLE: begin
        if (in_fire) begin
          err_d        = err_new;
          diff_d       = DIFF_W'(err_new) - DIFF_W'(prev_error_q);
          prev_error_d = err_new;
          state_d      = pdf_pkg::ST_MUL_I;
        end
      end
      pdf_pkg::ST_MUL_I: begin
        mul_en  = 1'b1;
        mul_a   = MUL_A_W'($signed(cfg.gain_i));
        mul_b   = MUL_B_W'(err_q);
        state_d = active ? pdf_pkg::ST_ACC : pdf_pkg::ST_OUT;
      end
      pdf_pkg::ST_ACC: begin
        acc_d   = acc_q + prod;
        mul_en  = 1'b1;
        mul_a   = MUL_A_W'($signed(cfg.gain_p));
        mul_b   = MUL_B_W'(err_q);
        state_d = pdf_pkg::ST_CLAMP;
      end
      pdf_pkg::ST_CLAMP: begin
        priority if (acc_q > lim) begin
          acc_d = lim;
        end else if (acc_q < lim_neg) begin
          acc_d = lim_neg;
        end else begin
          acc_d = acc_q;
        end
        sum_d   = SUM_W'(prod);                     // P term
        mul_en  = 1'b1;
        mul_a   = MUL_A_W'($signed(cfg.gain_d));
        mul_b   = MUL_B_W'(diff_q);
        state_d = pdf_pkg::ST_SUM;
      end
      pdf_pkg::ST_SUM: begin
        // floor of the integral is the arithmetic shift
        sum_d   = sum_q + SUM_W'(prod) + SUM_W'(acc_q >>> KI_FRAC_BITS);
        state_d = pdf_pkg::ST_MUL_N;
      end
      pdf_pkg::ST_MUL_N: begin
        mul_en  = 1'b1;
        mul_a   = MUL_A_W'(pdf_pkg::FILT_NEW);
        mul_b   = MUL_B_W'(sum_q);
        state_d = pdf_pkg::ST_MUL_O;
      end
      pdf_pkg::ST_MUL_O: begin
        filt_d  = FILT_W'(prod);
        mul_en  = 1'b1;
        mul_a   = MUL_A_W'(pdf_pkg::FILT_OLD);
        mul_b   = MUL_B_W'(prev_drive_q);
        state_d = pdf_pkg::ST_FILT;
      end
      pdf_pkg::ST_FILT: begin
        filt_d  = filt_q + FILT_W'(prod);
        state_d = pdf_pkg::ST_SAT;
      end
      pdf_pkg::ST_SAT: begin
        priority if (filt_sh > mo_pos) begin
          prev_drive_d = 16'(mo_pos);
        end else if (filt_sh < mo_neg) begin
          prev_drive_d = 16'(mo_neg);
        end else begin
          prev_drive_d = 16'(filt_sh);
        end
        state_d = pdf_pkg::ST_OUT;
      end
      pdf_pkg::ST_OUT: begin
        // wait here while an earlier result is still stalled
        if (out_free) begin
          drive_d       = prev_drive_q;
          drive_valid_d = 1'b1;
          state_d       = pdf_pkg::ST_IDLE;
        end
      end
      default: state_d = pdf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= pdf_pkg::ST_IDLE;
      prev_error_q  <= '0;
      acc_q         <= '0;
      prev_drive_q  <= '0;
      drive_valid_q <= 1'b0;
    end else begin
      state_q       <= state_d;
      prev_error_q  <= prev_error_d;
      acc_q         <= acc_d;
      prev_drive_q  <= prev_drive_d;
      drive_valid_q <= drive_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    err_q   <= err_d;
    diff_q  <= diff_d;
    sum_q   <= sum_d;
    filt_q  <= filt_d;
    drive_q <= drive_d;
  end

  assign measure_stall_o = (state_q != pdf_pkg::ST_IDLE);
  assign drive_o         = drive_q;
  assign drive_valid_o   = drive_valid_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_valid_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(drive_valid_q) |-> $past(state_q == pdf_pkg::ST_OUT))
    else $error("drive valid rose outside the output step");

  a_int_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pdf_pkg::ST_SUM) |-> (acc_q <= lim && acc_q >= lim_neg))
    else $error("integral outside its limit after clamp");

  a_drive_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pdf_pkg::ST_OUT && $past(state_q == pdf_pkg::ST_SAT)) |->
      (SAT_W'(prev_drive_q) <= mo_pos && SAT_W'(prev_drive_q) >= mo_neg))
    else $error("drive beyond max_output after saturation");

endmodule
`default_nettype wire
